// ----- hw/rtl/uint16_to_decimal_ascii_top_defines.svh -----
// Assertion macros for the uint16_to_decimal_ascii block.
`ifndef UINT16_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define UINT16_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define U16DA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define U16DA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define U16DA_ASSERT(lbl, clk, rst, prop, msg)
`define U16DA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/u16da_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package u16da_pkg;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned WIDE_W     = VALUE_W + 1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  localparam logic [WIDE_W-1:0] PLACE_WEIGHT [NUM_DIGITS] = '{
    17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  // Partial conversion carried from cell to cell.
  typedef struct packed {
    logic [VALUE_W-1:0]                  rest;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;  // index 0 = newest digit
    logic [COUNT_W-1:0]                  count;
  } beat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/u16da_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module u16da_cell #(
  parameter int unsigned PLACE = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire u16da_pkg::beat_t in_beat,
  output logic                 in_ready,
  output logic                 out_valid,
  output u16da_pkg::beat_t     out_beat,
  input  wire logic            out_ready
);
  import u16da_pkg::*;

  logic [WIDE_W-1:0]  rest_ext;
  logic [WIDE_W-1:0]  step;
  logic [WIDE_W-1:0]  sub;
  logic [DIGIT_W-1:0] digit;
  logic               append;
  beat_t              beat_next;

  // Digit by nine parallel compares against multiples of the place weight.
  always_comb begin
    rest_ext = {1'b0, in_beat.rest};
    digit    = '0;
    sub      = '0;
    step     = '0;
    for (int k = 1; k <= 9; k++) begin
      step = WIDE_W'(k * PLACE_WEIGHT[PLACE]);
      if (rest_ext >= step) begin
        digit = DIGIT_W'(k);
        sub   = step;
      end
    end
    append = (digit != '0) || (in_beat.count != '0) || (PLACE == NUM_DIGITS - 1);
    beat_next.rest = VALUE_W'(rest_ext - sub);
    if (append) begin
      beat_next.digits[NUM_DIGITS-1:1] = in_beat.digits[NUM_DIGITS-2:0];
      beat_next.digits[0]              = digit;
      beat_next.count                  = COUNT_W'(in_beat.count + 1'b1);
    end else begin
      beat_next.digits = in_beat.digits;
      beat_next.count  = in_beat.count;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/u16da_ser.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "uint16_to_decimal_ascii_top_defines.svh"
module u16da_ser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire u16da_pkg::beat_t            in_beat,
  output logic                             in_ready,
  output logic                             char_valid,
  input  wire logic                        char_stall,
  output logic [u16da_pkg::CHAR_W-1:0]     ascii_char,
  output logic [u16da_pkg::COUNT_W-1:0]    digit_count,
  output logic                             last
);
  import u16da_pkg::*;

  logic                               busy;
  logic [POS_W-1:0]                   pos;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic [COUNT_W-1:0]                 count;
  logic                               slot_free;

  assign slot_free = !char_valid || !char_stall;
  assign in_ready  = !busy || (slot_free && (pos == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        char_valid <= busy;
      end
      if (slot_free && busy) begin
        ascii_char  <= ASCII_ZERO + CHAR_W'(digits[pos]);
        digit_count <= count;
        last        <= (pos == '0);
        pos         <= POS_W'(pos - 1'b1);
        busy        <= (pos != '0);
      end
      if (in_valid && in_ready) begin
        busy   <= 1'b1;
        digits <= in_beat.digits;
        count  <= in_beat.count;
        pos    <= POS_W'(in_beat.count - 1'b1);
      end
    end
  end

  `U16DA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !char_valid, "output valid after reset")
  `U16DA_ASSERT(a_count_range, clk, rst, char_valid |-> (digit_count >= 3'd1) && (digit_count <= 3'd5), "digit count out of range")
  `U16DA_ASSERT(a_char_range, clk, rst, char_valid |-> (ascii_char >= 6'd48) && (ascii_char <= 6'd57), "character not a digit")
  `U16DA_ASSERT(a_no_gap, clk, rst, (char_valid && !char_stall && !last) |=> char_valid && (digit_count == $past(digit_count)), "string broken mid value")

endmodule
`default_nettype wire

// ----- hw/rtl/uint16_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Converts a 16-bit unsigned value to decimal ASCII, most significant digit first, leading
// zeros dropped (zero gives one '0'). Each output beat carries one character, the value's digit
// count and a last flag on its final character. A value walks through five registered digit
// cells, then a serializer that registers each character.
// The single character output sets the sustained rate: a value of N digits (1 to 5) takes N
// character beats, and the serializer takes the next value while it emits the last character.
module uint16_to_decimal_ascii_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           value_valid,
  output logic                                value_stall,
  input  wire logic [u16da_pkg::VALUE_W-1:0]  value,
  output logic                                char_valid,
  input  wire logic                           char_stall,
  output logic [u16da_pkg::CHAR_W-1:0]        ascii_char,
  output logic [u16da_pkg::COUNT_W-1:0]       digit_count,
  output logic                                last
);
  import u16da_pkg::*;

  logic  valid [NUM_DIGITS+1];
  logic  ready [NUM_DIGITS+1];
  beat_t beat  [NUM_DIGITS+1];

  assign valid[0]        = value_valid;
  assign beat[0].rest    = value;
  assign beat[0].digits  = '0;
  assign beat[0].count   = '0;
  assign value_stall     = !ready[0];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    u16da_cell #(
      .PLACE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_beat   (beat[i]),
      .in_ready  (ready[i]),
      .out_valid (valid[i+1]),
      .out_beat  (beat[i+1]),
      .out_ready (ready[i+1])
    );
  end

  u16da_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (valid[NUM_DIGITS]),
    .in_beat     (beat[NUM_DIGITS]),
    .in_ready    (ready[NUM_DIGITS]),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .ascii_char  (ascii_char),
    .digit_count (digit_count),
    .last        (last)
  );

endmodule
`default_nettype wire

// ----- dv/tb_uint16_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
module tb_uint16_to_decimal_ascii_top;
  import u16da_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 103;
  localparam int unsigned DRAIN_CYCLES  = 20;

  typedef struct {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] count;
    logic               lst;
    logic [VALUE_W-1:0] src;
  } decimal_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                value_valid = 1'b0;
  logic                value_stall;
  logic [VALUE_W-1:0]  value = '0;
  logic                char_valid;
  logic                char_stall = 1'b0;
  logic [CHAR_W-1:0]   ascii_char;
  logic [COUNT_W-1:0]  digit_count;
  logic                last;

  logic [VALUE_W-1:0]  pending_values[$];
  decimal_char_t       expected_chars[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  uint16_to_decimal_ascii_top dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .ascii_char  (ascii_char),
    .digit_count (digit_count),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Decimal digits, most significant first, leading zeros dropped.
  task automatic predict_decimal_chars(input logic [VALUE_W-1:0] v);
    int unsigned   rest;
    int unsigned   n;
    logic [3:0]    dig[NUM_DIGITS];
    decimal_char_t c;
    rest = 32'(v);
    n = 0;
    do begin
      dig[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      c.ch    = ASCII_ZERO + CHAR_W'(dig[k]);
      c.count = COUNT_W'(n);
      c.lst   = (k == 0);
      c.src   = v;
      expected_chars.push_back(c);
    end
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return VALUE_W'($urandom_range(0, 9));
      1: return VALUE_W'($urandom_range(10, 99));
      2: return VALUE_W'($urandom_range(100, 999));
      3: return VALUE_W'($urandom_range(1000, 9999));
      4: return VALUE_W'($urandom_range(10000, 65535));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // value driver
  always @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else begin
      if (value_valid && !value_stall) begin
        predict_decimal_chars(value);
      end
      if (!value_valid || !value_stall) begin
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          value       <= pending_values.pop_front();
          value_valid <= 1'b1;
        end else begin
          value_valid <= 1'b0;
        end
      end
    end
  end

  // char receiver and checker
  always @(posedge clk) begin : char_monitor
    decimal_char_t want;
    char_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (!rst && char_valid && !char_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("char beat with nothing expected: char %0d", ascii_char));
      end else begin
        want = expected_chars.pop_front();
        if (ascii_char !== want.ch)
          report_mismatch($sformatf("value %0d: ascii_char %0d, want %0d",
                                    want.src, ascii_char, want.ch));
        if (digit_count !== want.count)
          report_mismatch($sformatf("value %0d: digit_count %0d, want %0d",
                                    want.src, digit_count, want.count));
        if (last !== want.lst)
          report_mismatch($sformatf("value %0d: last %0b, want %0b",
                                    want.src, last, want.lst));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned idle_tbl[4];
    int unsigned stall_tbl[4];
    idle_tbl  = '{0, 86, 0, 15};
    stall_tbl = '{0, 0, 86, 15};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // digit-length boundaries, zero, max, bit patterns
    pending_values = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd999,
                       16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd12345, 16'd54321,
                       16'd32768, 16'd65534, 16'd65535, 16'hAAAA, 16'h5555, 16'd90,
                       16'd9000};

    // random phases start only after every char of the directed set is out
    while (pending_values.size() != 0 || value_valid || expected_chars.size() != 0)
      @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tbl[p];
      recv_stall_pct = stall_tbl[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        pending_values.push_back(random_value());
      while (pending_values.size() != 0 || value_valid || expected_chars.size() != 0)
        @(posedge clk);
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
